[src/round_robin_tick_scheduler_unit_macros.svh]
// assertion helpers, clocked on clk and held off during rst
`ifndef ROUND_ROBIN_TICK_SCHEDULER_UNIT_MACROS_SVH
`define ROUND_ROBIN_TICK_SCHEDULER_UNIT_MACROS_SVH

// property checked at every edge
`define RRTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition on one edge implies a consequence on the next
`define RRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/rrts_pkg.sv]
package rrts_pkg;

  localparam int MAX_PROCESSES = 16;
  localparam int SLOT_W = $clog2(MAX_PROCESSES);
  localparam int COUNT_W = $clog2(MAX_PROCESSES + 1);

  localparam int ID_W = 8;
  localparam int TIME_W = 16;
  localparam int STATUS_W = 3;
  localparam int OCC_W = 5;

  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED  = 3'd0,
    ST_FULL   = 3'd1,
    ST_ZERO   = 3'd2,
    ST_SERVED = 3'd3,
    ST_DONE   = 3'd4,
    ST_EMPTY  = 3'd5
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] time_left;
    logic [SLOT_W-1:0] next;
  } entry_t;

  typedef struct packed {
    logic              set;
    logic              clr;
    logic [SLOT_W-1:0] set_slot;
    logic [SLOT_W-1:0] clr_slot;
  } alloc_cmd_t;

endpackage

[src/rrts_in_if.sv]
interface rrts_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [rrts_pkg::ID_W-1:0]   process_id;
  logic [rrts_pkg::TIME_W-1:0] exec_time;

  modport source (output valid, output kind, output process_id, output exec_time,
                  input ready);
  modport sink (input valid, input kind, input process_id, input exec_time,
                output ready);
endinterface

[src/rrts_out_if.sv]
interface rrts_out_if;
  logic                         valid;
  logic                         ready;
  logic [rrts_pkg::STATUS_W-1:0] status;
  logic [rrts_pkg::ID_W-1:0]     served_id;
  logic [rrts_pkg::TIME_W-1:0]   remaining;
  logic [rrts_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, output status, output served_id, output remaining,
                  output occupancy, input ready);
  modport sink (input valid, input status, input served_id, input remaining,
                input occupancy, output ready);
endinterface

[src/round_robin_tick_scheduler_unit.sv]
// add: written from idle into an empty ring, else via S_ADD_LINK and S_ADD_TAIL; rejects
//   and empty ticks go straight to the result; tick: a process that stays or the last entry
//   that finishes goes through S_TICK_EX, one finishing in a longer ring then walks the ring
//   from the tail to its predecessor (fewer than MAX_PROCESSES steps), one entry read a cycle
//   through the entry memory; throughput: one item at a time, next item taken once the result is registered
// reset: rst (synchronous) empties the ring; entry memory is not cleared
`include "round_robin_tick_scheduler_unit_macros.svh"

module round_robin_tick_scheduler_unit (
  input logic        clk,
  input logic        rst,
  rrts_in_if.sink    in_ch,
  rrts_out_if.source out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_LINK,
    S_ADD_TAIL,
    S_TICK_EX,
    S_SEARCH,
    S_RESULT
  } state_t;

  state_t                               state;
  logic [rrts_pkg::SLOT_W-1:0]          tail;
  logic [rrts_pkg::SLOT_W-1:0]          cur;
  logic [rrts_pkg::COUNT_W-1:0]         count;
  logic [rrts_pkg::ID_W-1:0]            new_id;
  logic [rrts_pkg::TIME_W-1:0]          new_time;
  logic [rrts_pkg::SLOT_W-1:0]          new_slot;
  rrts_pkg::entry_t                     tail_word;
  logic [rrts_pkg::SLOT_W-1:0]          rm_slot;
  logic [rrts_pkg::SLOT_W-1:0]          succ;
  logic [rrts_pkg::SLOT_W-1:0]          prev;
  rrts_pkg::status_t                    res_status;
  logic [rrts_pkg::ID_W-1:0]            res_id;
  logic [rrts_pkg::TIME_W-1:0]          res_rem;

  logic                                 out_valid;
  logic [rrts_pkg::STATUS_W-1:0]        out_status;
  logic [rrts_pkg::ID_W-1:0]            out_id;
  logic [rrts_pkg::TIME_W-1:0]          out_rem;
  logic [rrts_pkg::OCC_W-1:0]           out_occ;

  rrts_pkg::entry_t                     mem [rrts_pkg::MAX_PROCESSES];
  rrts_pkg::entry_t                     rdata;
  rrts_pkg::entry_t                     wdata;
  logic                                 re;
  logic                                 we;
  logic [rrts_pkg::SLOT_W-1:0]          raddr;
  logic [rrts_pkg::SLOT_W-1:0]          waddr;

  rrts_pkg::alloc_cmd_t                 alloc_cmd;
  logic [rrts_pkg::SLOT_W-1:0]          free_slot;
  logic                                 any_free;

  logic                                 ring_full;
  logic                                 add_first;
  logic                                 add_link;
  logic [rrts_pkg::TIME_W-1:0]          dec;

  rrts_slot_alloc u_alloc (
    .clk       (clk),
    .rst       (rst),
    .cmd       (alloc_cmd),
    .free_slot (free_slot),
    .any_free  (any_free)
  );

  assign ring_full = (count >= rrts_pkg::COUNT_W'(rrts_pkg::MAX_PROCESSES)) || !any_free;
  assign add_first = !ring_full && (in_ch.exec_time != '0) && (count == '0);
  assign add_link = !ring_full && (in_ch.exec_time != '0) && (count != '0);
  // saturating decrement of the served entry
  assign dec = (rdata.time_left == '0) ? '0 : rdata.time_left - 1'b1;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  always_comb begin
    re = 1'b0;
    raddr = tail;
    we = 1'b0;
    waddr = tail;
    wdata = '0;
    alloc_cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.kind == rrts_pkg::KIND_ADD) begin
            if (add_first) begin
              // a lone entry points at itself
              we = 1'b1;
              waddr = free_slot;
              wdata = '{id: in_ch.process_id, time_left: in_ch.exec_time, next: free_slot};
              alloc_cmd.set = 1'b1;
              alloc_cmd.set_slot = free_slot;
            end else if (add_link) begin
              re = 1'b1;
              raddr = tail;
            end
          end else if (count != '0) begin
            re = 1'b1;
            raddr = cur;
          end
        end
      end
      S_ADD_LINK: begin
        we = 1'b1;
        waddr = new_slot;
        wdata = '{id: new_id, time_left: new_time, next: rdata.next};
      end
      S_ADD_TAIL: begin
        we = 1'b1;
        waddr = tail;
        wdata = '{id: tail_word.id, time_left: tail_word.time_left, next: new_slot};
        alloc_cmd.set = 1'b1;
        alloc_cmd.set_slot = new_slot;
      end
      S_TICK_EX: begin
        we = 1'b1;
        waddr = cur;
        wdata = '{id: rdata.id, time_left: dec, next: rdata.next};
        if (dec == '0) begin
          alloc_cmd.clr = 1'b1;
          alloc_cmd.clr_slot = cur;
          if (count > rrts_pkg::COUNT_W'(1)) begin
            re = 1'b1;
            raddr = tail;
          end
        end
      end
      S_SEARCH: begin
        if (rdata.next == rm_slot) begin
          // bypass the finished entry
          we = 1'b1;
          waddr = prev;
          wdata = '{id: rdata.id, time_left: rdata.time_left, next: succ};
        end else begin
          re = 1'b1;
          raddr = rdata.next;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tail <= '0;
      cur <= '0;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ch.ready && state != S_RESULT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            new_id <= in_ch.process_id;
            new_time <= in_ch.exec_time;
            new_slot <= free_slot;
            res_id <= '0;
            res_rem <= '0;
            if (in_ch.kind == rrts_pkg::KIND_ADD) begin
              if (ring_full) begin
                res_status <= rrts_pkg::ST_FULL;
                state <= S_RESULT;
              end else if (in_ch.exec_time == '0) begin
                res_status <= rrts_pkg::ST_ZERO;
                state <= S_RESULT;
              end else if (count == '0) begin
                tail <= free_slot;
                cur <= free_slot;
                count <= count + 1'b1;
                res_status <= rrts_pkg::ST_ADDED;
                state <= S_RESULT;
              end else begin
                state <= S_ADD_LINK;
              end
            end else if (count == '0) begin
              res_status <= rrts_pkg::ST_EMPTY;
              state <= S_RESULT;
            end else begin
              state <= S_TICK_EX;
            end
          end
        end
        S_ADD_LINK: begin
          tail_word <= rdata;
          state <= S_ADD_TAIL;
        end
        S_ADD_TAIL: begin
          tail <= new_slot;
          count <= count + 1'b1;
          res_status <= rrts_pkg::ST_ADDED;
          state <= S_RESULT;
        end
        S_TICK_EX: begin
          res_id <= rdata.id;
          cur <= rdata.next;
          if (dec != '0) begin
            res_status <= rrts_pkg::ST_SERVED;
            res_rem <= dec;
            state <= S_RESULT;
          end else begin
            res_status <= rrts_pkg::ST_DONE;
            res_rem <= '0;
            if (count <= rrts_pkg::COUNT_W'(1)) begin
              count <= '0;
              state <= S_RESULT;
            end else begin
              rm_slot <= cur;
              succ <= rdata.next;
              prev <= tail;
              state <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (rdata.next == rm_slot) begin
            if (rm_slot == tail) tail <= prev;
            count <= count - 1'b1;
            state <= S_RESULT;
          end else begin
            prev <= rdata.next;
          end
        end
        S_RESULT: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            out_status <= res_status;
            out_id <= res_id;
            out_rem <= res_rem;
            out_occ <= rrts_pkg::OCC_W'(count);
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.status = out_status;
  assign out_ch.served_id = out_id;
  assign out_ch.remaining = out_rem;
  assign out_ch.occupancy = out_occ;

  `RRTS_ASSERT(a_count_bound, count <= rrts_pkg::COUNT_W'(rrts_pkg::MAX_PROCESSES), "ring count over capacity")
  `RRTS_ASSERT_NEXT(a_accept_leaves_idle, in_ch.valid && in_ch.ready, state != S_IDLE, "item taken but block stayed idle")
  `RRTS_ASSERT(a_result_from_fsm, !$rose(out_valid) || $past(state) == S_RESULT, "result appeared without completion")
  `RRTS_ASSERT(a_single_entry_ring, !(state == S_IDLE && count == rrts_pkg::COUNT_W'(1)) || tail == cur, "lone entry is not both tail and current")

endmodule

[src/rrts_slot_alloc.sv]
`include "round_robin_tick_scheduler_unit_macros.svh"

module rrts_slot_alloc (
  input  logic                          clk,
  input  logic                          rst,
  input  rrts_pkg::alloc_cmd_t          cmd,
  output logic [rrts_pkg::SLOT_W-1:0]   free_slot,
  output logic                          any_free
);

  logic [rrts_pkg::MAX_PROCESSES-1:0] used;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      if (cmd.set) used[cmd.set_slot] <= 1'b1;
      if (cmd.clr) used[cmd.clr_slot] <= 1'b0;
    end
  end

  // lowest-numbered free slot wins
  always_comb begin
    free_slot = '0;
    any_free = 1'b0;
    for (int i = rrts_pkg::MAX_PROCESSES - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_slot = rrts_pkg::SLOT_W'(i);
        any_free = 1'b1;
      end
    end
  end

  `RRTS_ASSERT(a_no_set_and_clr, !(cmd.set && cmd.clr), "slot set and cleared together")
  `RRTS_ASSERT(a_set_free_slot, !cmd.set || !used[cmd.set_slot], "allocating a used slot")
  `RRTS_ASSERT(a_clr_used_slot, !cmd.clr || used[cmd.clr_slot], "releasing a free slot")

endmodule

[tb/round_robin_tick_scheduler_unit_test.sv]
module round_robin_tick_scheduler_unit_test;

  localparam int RANDOM_ITEMS = 1800;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int PLAN_LEN = 13;
  localparam logic [7:0] RX_PATTERN = 8'b1011_0010;

  typedef struct packed {
    rrts_pkg::status_t           status;
    logic [rrts_pkg::ID_W-1:0]   served;
    logic [rrts_pkg::TIME_W-1:0] rem;
    logic [rrts_pkg::OCC_W-1:0]  occ;
  } outcome_t;

  typedef struct packed {
    logic                        kind;
    logic [rrts_pkg::ID_W-1:0]   pid;
    logic [rrts_pkg::TIME_W-1:0] t;
    logic [7:0]                  reps;
    logic                        typed;
    outcome_t                    want;
  } plan_row_t;

  logic clk;
  logic rst;

  rrts_in_if in_ch ();
  rrts_out_if out_ch ();

  round_robin_tick_scheduler_unit dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // ring as the scheduler should hold it
  logic [rrts_pkg::ID_W-1:0]          ring_pid [rrts_pkg::MAX_PROCESSES];
  logic [rrts_pkg::TIME_W-1:0]        ring_left [rrts_pkg::MAX_PROCESSES];
  logic [rrts_pkg::SLOT_W-1:0]        ring_link [rrts_pkg::MAX_PROCESSES];
  logic [rrts_pkg::MAX_PROCESSES-1:0] ring_busy = '0;
  logic [rrts_pkg::SLOT_W-1:0]        ring_tail = '0;
  logic [rrts_pkg::SLOT_W-1:0]        ring_cur = '0;
  logic [rrts_pkg::COUNT_W-1:0]       ring_count = '0;

  outcome_t pending_results [$];
  outcome_t head_result;
  plan_row_t plan [PLAN_LEN];

  int  fail_count = 0;
  int  cycle_count = 0;
  int  burst_left = 0;
  bit  offering = 1'b0;
  bit  hold_req = 1'b0;

  function automatic outcome_t ring_step(input logic k, input logic [rrts_pkg::ID_W-1:0] pid,
                                         input logic [rrts_pkg::TIME_W-1:0] t);
    outcome_t                    res;
    int                          s;
    logic [rrts_pkg::SLOT_W-1:0] slot;
    logic [rrts_pkg::SLOT_W-1:0] c;
    logic [rrts_pkg::SLOT_W-1:0] prev;
    logic [rrts_pkg::TIME_W-1:0] left;
    bit                          found;
    res = '{rrts_pkg::ST_ADDED, '0, '0, '0};
    slot = '0;
    if (k == rrts_pkg::KIND_ADD) begin
      if (ring_count >= rrts_pkg::MAX_PROCESSES) begin
        res.status = rrts_pkg::ST_FULL;
      end else if (t == '0) begin
        res.status = rrts_pkg::ST_ZERO;
      end else begin
        // lowest free slot wins
        for (s = rrts_pkg::MAX_PROCESSES - 1; s >= 0; s--)
          if (!ring_busy[s]) slot = rrts_pkg::SLOT_W'(s);
        ring_pid[slot] = pid;
        ring_left[slot] = t;
        ring_busy[slot] = 1'b1;
        if (ring_count == 0) begin
          ring_link[slot] = slot;
          ring_tail = slot;
          ring_cur = slot;
        end else begin
          ring_link[slot] = ring_link[ring_tail];
          ring_link[ring_tail] = slot;
          ring_tail = slot;
        end
        ring_count++;
      end
    end else if (ring_count == 0) begin
      res.status = rrts_pkg::ST_EMPTY;
    end else begin
      c = ring_cur;
      left = ring_left[c];
      if (left != '0) left--;
      ring_left[c] = left;
      res.served = ring_pid[c];
      if (left == '0) begin
        res.status = rrts_pkg::ST_DONE;
        ring_cur = ring_link[c];
        ring_busy[c] = 1'b0;
        if (ring_count <= 1) begin
          ring_count = '0;
        end else begin
          // walk from the tail to the entry pointing at the one leaving
          prev = ring_tail;
          found = 1'b0;
          for (s = 0; s < rrts_pkg::MAX_PROCESSES; s++) begin
            if (!found) begin
              if (ring_link[prev] == c) found = 1'b1;
              else prev = ring_link[prev];
            end
          end
          ring_link[prev] = ring_link[c];
          if (c == ring_tail) ring_tail = prev;
          ring_count--;
        end
      end else begin
        res.status = rrts_pkg::ST_SERVED;
        res.rem = left;
        ring_cur = ring_link[c];
      end
    end
    res.occ = ring_count;
    return res;
  endfunction

  task automatic transfer_in(input logic k, input logic [rrts_pkg::ID_W-1:0] pid,
                             input logic [rrts_pkg::TIME_W-1:0] t);
    in_ch.valid <= 1'b1;
    in_ch.kind <= k;
    in_ch.process_id <= pid;
    in_ch.exec_time <= t;
    offering = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic stop_offer();
    if (offering) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1) ? $urandom_range(1, 12) : $urandom_range(30, 120);
      gap = $urandom_range(1, 10);
      stop_offer();
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    stop_offer();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic issue(input logic k, input logic [rrts_pkg::ID_W-1:0] pid,
                       input logic [rrts_pkg::TIME_W-1:0] t);
    transfer_in(k, pid, t);
    pending_results.push_back(ring_step(k, pid, t));
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transfer: status %0d id %0d", out_ch.status, out_ch.served_id);
        fail_count++;
      end else begin
        head_result = pending_results.pop_front();
        if (out_ch.status !== head_result.status) begin
          $error("status: expected %0d, got %0d", head_result.status, out_ch.status);
          fail_count++;
        end
        if (out_ch.served_id !== head_result.served) begin
          $error("served_id: expected %0d, got %0d", head_result.served, out_ch.served_id);
          fail_count++;
        end
        if (out_ch.remaining !== head_result.rem) begin
          $error("remaining: expected %0d, got %0d", head_result.rem, out_ch.remaining);
          fail_count++;
        end
        if (out_ch.occupancy !== head_result.occ) begin
          $error("occupancy: expected %0d, got %0d", head_result.occ, out_ch.occupancy);
          fail_count++;
        end
      end
    end
  end

  // receiver: modes of always ready, coin toss and a fixed pattern, plus long holds
  initial begin
    int mode;
    int mode_left;
    int rx_cycle;
    mode = 0;
    mode_left = 0;
    rx_cycle = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(2);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(1));
          default: out_ch.ready <= RX_PATTERN[rx_cycle % 8];
        endcase
      end
    end
  end

  initial begin
    int                          i;
    int                          r;
    int                          done_random;
    int                          phase_no;
    int                          phase_len;
    int                          add_pct;
    int                          big_left;
    int                          pick;
    logic                        k;
    logic [rrts_pkg::ID_W-1:0]   pid;
    logic [rrts_pkg::TIME_W-1:0] t;
    outcome_t                    got;

    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.kind <= rrts_pkg::KIND_ADD;
    in_ch.process_id <= '0;
    in_ch.exec_time <= '0;

    plan[0]  = '{rrts_pkg::KIND_TICK, 8'd0, 16'd0, 8'd1, 1'b1,
                 '{rrts_pkg::ST_EMPTY, 8'd0, 16'd0, 5'd0}};
    plan[1]  = '{rrts_pkg::KIND_ADD, 8'hA5, 16'd0, 8'd1, 1'b1,
                 '{rrts_pkg::ST_ZERO, 8'd0, 16'd0, 5'd0}};
    plan[2]  = '{rrts_pkg::KIND_ADD, 8'd0, 16'd1, 8'd1, 1'b1,
                 '{rrts_pkg::ST_ADDED, 8'd0, 16'd0, 5'd1}};
    // only entry finishes, then a tick on the emptied ring
    plan[3]  = '{rrts_pkg::KIND_TICK, 8'd0, 16'd0, 8'd1, 1'b1,
                 '{rrts_pkg::ST_DONE, 8'd0, 16'd0, 5'd0}};
    plan[4]  = '{rrts_pkg::KIND_TICK, 8'hFF, 16'hFFFF, 8'd1, 1'b1,
                 '{rrts_pkg::ST_EMPTY, 8'd0, 16'd0, 5'd0}};
    plan[5]  = '{rrts_pkg::KIND_ADD, 8'hFF, 16'hFFFF, 8'd1, 1'b1,
                 '{rrts_pkg::ST_ADDED, 8'd0, 16'd0, 5'd1}};
    plan[6]  = '{rrts_pkg::KIND_ADD, 8'h11, 16'd1, 8'd1, 1'b1,
                 '{rrts_pkg::ST_ADDED, 8'd0, 16'd0, 5'd2}};
    plan[7]  = '{rrts_pkg::KIND_TICK, 8'd0, 16'd0, 8'd1, 1'b1,
                 '{rrts_pkg::ST_SERVED, 8'hFF, 16'hFFFE, 5'd2}};
    // the tail itself finishes
    plan[8]  = '{rrts_pkg::KIND_TICK, 8'd0, 16'd0, 8'd1, 1'b1,
                 '{rrts_pkg::ST_DONE, 8'h11, 16'd0, 5'd1}};
    plan[9]  = '{rrts_pkg::KIND_ADD, 8'd16, 16'd2, 8'd15, 1'b0, '0};
    // full ring is reported ahead of a zero time
    plan[10] = '{rrts_pkg::KIND_ADD, 8'd0, 16'd0, 8'd1, 1'b1,
                 '{rrts_pkg::ST_FULL, 8'd0, 16'd0, 5'd16}};
    plan[11] = '{rrts_pkg::KIND_ADD, 8'h5A, 16'hA5A5, 8'd1, 1'b1,
                 '{rrts_pkg::ST_FULL, 8'd0, 16'd0, 5'd16}};
    plan[12] = '{rrts_pkg::KIND_TICK, 8'd0, 16'd0, 8'd40, 1'b0, '0};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < PLAN_LEN; i++) begin
      for (r = 0; r < plan[i].reps; r++) begin
        pid = rrts_pkg::ID_W'(plan[i].pid + r);
        transfer_in(plan[i].kind, pid, plan[i].t);
        got = ring_step(plan[i].kind, pid, plan[i].t);
        pending_results.push_back(plan[i].typed ? plan[i].want : got);
        pace_sender();
      end
    end

    done_random = 0;
    phase_no = 0;
    big_left = 2;
    while (done_random < RANDOM_ITEMS) begin
      phase_len = $urandom_range(20, 120);
      case ($urandom_range(4))
        0: add_pct = 10;
        1: add_pct = 35;
        2: add_pct = 50;
        3: add_pct = 65;
        default: add_pct = 90;
      endcase
      if (phase_no == 1 || phase_no == 6) hold_req = 1'b1;
      repeat (phase_len) begin
        k = ($urandom_range(99) < add_pct) ? rrts_pkg::KIND_ADD : rrts_pkg::KIND_TICK;
        pid = rrts_pkg::ID_W'($urandom_range(255));
        t = rrts_pkg::TIME_W'($urandom_range(65535));
        if (k == rrts_pkg::KIND_ADD) begin
          pick = $urandom_range(99);
          if (pick < 5) t = '0;
          else if (pick < 80) t = rrts_pkg::TIME_W'($urandom_range(1, 4));
          else if (pick < 95) t = rrts_pkg::TIME_W'($urandom_range(5, 40));
          else if (ring_count >= rrts_pkg::MAX_PROCESSES) begin
            t = rrts_pkg::TIME_W'($urandom_range(65535));
          end else if (big_left > 0) begin
            // a long job stays in the ring for the rest of the run
            big_left--;
            t = rrts_pkg::TIME_W'($urandom_range(32768, 65535));
          end else t = rrts_pkg::TIME_W'($urandom_range(1, 8));
        end
        issue(k, pid, t);
        done_random++;
        pace_sender();
      end
      if (phase_no == 0 || $urandom_range(3) == 0) drain();
      phase_no++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[round_robin_tick_scheduler_unit.f]
+incdir+src
src/rrts_pkg.sv
src/rrts_in_if.sv
src/rrts_out_if.sv
src/rrts_slot_alloc.sv
src/round_robin_tick_scheduler_unit.sv
tb/round_robin_tick_scheduler_unit_test.sv
